FILE: sv/hslc_pkg.sv
// Shared constants, types and the hue ramp for the HSL colorize blend block.
`default_nettype none
package hslc_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_HUE    = 2'd0;
	localparam logic [1:0] CFG_SAT    = 2'd1;
	localparam logic [1:0] CFG_WEIGHT = 2'd2;

	localparam logic [8:0]  WEIGHT_FULL = 9'd256;
	// p and q are numerators over 510*255
	localparam logic [17:0] DEN     = 18'd130050;
	// final divide: blended numerator >> 9, then / 255^2
	localparam logic [15:0] DIVISOR = 16'd65025;
	// floor(2^32 / 65025)
	localparam logic [16:0] RECIP   = 17'd66051;

	// hue positions in 1/1530 of the wheel
	localparam logic [10:0] POS_SIXTH      = 11'd255;
	localparam logic [10:0] POS_THIRD      = 11'd510;
	localparam logic [10:0] POS_HALF       = 11'd765;
	localparam logic [10:0] POS_TWO_THIRDS = 11'd1020;

	typedef struct packed {
		logic [17:0] pn;  // p numerator
		logic [17:0] d;   // q - p numerator
		logic [8:0]  w;   // clamped blend weight
	} hslc_terms_t;

	// ramp position, 0..255 from p toward q, for a wrapped hue position 0..1530
	function automatic logic [7:0] ramp_k(input logic [10:0] t);
		logic [10:0] diff;
		diff = POS_TWO_THIRDS - t;
		if (t < POS_SIXTH) begin
			ramp_k = t[7:0];
		end else if (t < POS_HALF) begin
			ramp_k = 8'd255;
		end else if (t < POS_TWO_THIRDS) begin
			ramp_k = diff[7:0];
		end else begin
			ramp_k = 8'd0;
		end
	endfunction

endpackage
`default_nettype wire

FILE: sv/hsl_colorize_blend.sv
// Top level of the HSL colorize blend block: config registers, pipeline control.
// One pixel word per clock, and the block never stalls,
// so busy stays low and each result is shown for one cycle with done high. The
// depth is set by the per-channel blend multiply and the exact divide by 255^2
// (reciprocal multiply, then one correction step). Configuration is taken on
// every cycle (cfg_ready is high); writes to an index beyond blend_weight are dropped.
`default_nettype none
module hsl_colorize_blend (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	input  logic [7:0] alpha_in,
	output logic       done,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out,
	output logic [7:0] alpha_out,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data
);
	import hslc_pkg::*;

	logic [7:0] hue_q;
	logic [7:0] sat_q;
	logic [8:0] weight_q;

	logic       accept;
	logic [7:0] mx, mn;
	logic [10:0] th;
	logic [10:0] t_r, t_g, t_b;

	logic       valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic [7:0] r_s1, g_s1, b_s1, a_s1;
	logic [8:0] m_s1;
	logic [7:0] kr_s1, kg_s1, kb_s1;

	logic [7:0] r_s2, g_s2, b_s2, a_s2;
	logic [7:0] kr_s2, kg_s2, kb_s2;
	logic [17:0] pn_s2, d_s2;
	logic [7:0] a_s3, a_s4, a_s5, a_s6;

	logic [16:0] ms;
	logic [8:0]  tail;
	logic [16:0] st;
	logic [16:0] x;
	logic [17:0] m255;
	hslc_terms_t terms;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_q    <= 8'd0;
			sat_q    <= 8'd0;
			weight_q <= WEIGHT_FULL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HUE:    hue_q    <= cfg_data[7:0];
				CFG_SAT:    sat_q    <= cfg_data[7:0];
				CFG_WEIGHT: weight_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// stage 1 logic: lightness sum and ramp positions
	always_comb begin
		mx = red_in;
		mn = red_in;
		if (green_in > mx) mx = green_in;
		if (blue_in > mx)  mx = blue_in;
		if (green_in < mn) mn = green_in;
		if (blue_in < mn)  mn = blue_in;
		th  = 11'({3'b0, hue_q} * 11'd6);
		t_g = th;
		t_r = (th > POS_TWO_THIRDS) ? th - POS_TWO_THIRDS : th + POS_THIRD;
		t_b = (th < POS_THIRD) ? th + POS_TWO_THIRDS : th - POS_THIRD;
	end

	// stage 2 logic: p and q-p; both branches stay non-negative
	always_comb begin
		ms   = {8'b0, m_s1} * {9'b0, sat_q};
		tail = 9'd510 - m_s1;
		st   = {9'b0, sat_q} * {8'b0, tail};
		x    = (m_s1 < 9'd255) ? ms : st;
		m255 = 18'({9'b0, m_s1} * 18'd255);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		r_s1  <= red_in;
		g_s1  <= green_in;
		b_s1  <= blue_in;
		a_s1  <= alpha_in;
		m_s1  <= {1'b0, mx} + {1'b0, mn};
		kr_s1 <= ramp_k(t_r);
		kg_s1 <= ramp_k(t_g);
		kb_s1 <= ramp_k(t_b);

		r_s2  <= r_s1;
		g_s2  <= g_s1;
		b_s2  <= b_s1;
		a_s2  <= a_s1;
		kr_s2 <= kr_s1;
		kg_s2 <= kg_s1;
		kb_s2 <= kb_s1;
		pn_s2 <= m255 - {1'b0, x};
		d_s2  <= {x, 1'b0};

		a_s3 <= a_s2;
		a_s4 <= a_s3;
		a_s5 <= a_s4;
		a_s6 <= a_s5;
	end

	assign terms.pn = pn_s2;
	assign terms.d  = d_s2;
	assign terms.w  = (weight_q > WEIGHT_FULL) ? WEIGHT_FULL : weight_q;

	hslc_channel u_red (
		.clk   (clk),
		.terms (terms),
		.k     (kr_s2),
		.src   (r_s2),
		.value (red_out)
	);

	hslc_channel u_green (
		.clk   (clk),
		.terms (terms),
		.k     (kg_s2),
		.src   (g_s2),
		.value (green_out)
	);

	hslc_channel u_blue (
		.clk   (clk),
		.terms (terms),
		.k     (kb_s2),
		.src   (b_s2),
		.value (blue_out)
	);

	assign done      = valid_s6;
	assign alpha_out = a_s6;

	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 6))
		else $error("result word without a start six cycles earlier");

	a_alpha_pass: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> alpha_out == $past(alpha_in, 6))
		else $error("alpha does not match its pixel");

	// zero saturation on a gray source must stay gray whatever the weight
	a_gray_stays_gray: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(sat_q, 5) == 8'd0
		 && $past(red_in == green_in && green_in == blue_in, 6))
		|-> (red_out == green_out && green_out == blue_out))
		else $error("gray pixel lost its gray at zero saturation");

	a_hue_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index == CFG_HUE) |=> hue_q == $past(cfg_data[7:0]))
		else $error("hue write not taken");

endmodule
`default_nettype wire

FILE: sv/hslc_channel.sv
// One color channel: rebuild from p/q, blend with source, exact divide and clamp.
`default_nettype none
module hslc_channel (
	input  logic                clk,
	input  hslc_pkg::hslc_terms_t terms,
	input  logic [7:0]          k,
	input  logic [7:0]          src,
	output logic [7:0]          value
);
	import hslc_pkg::*;

	logic [24:0] rec_s3;
	logic [16:0] sw_s3;
	logic [8:0]  w_s3;
	logic [34:0] num;
	logic [23:0] n_s4;
	logic [40:0] prod;
	logic [8:0]  q0_s5;
	logic [23:0] n_s5;
	logic [24:0] back;
	logic [24:0] rem;
	logic [8:0]  q;
	logic [7:0]  value_s6;

	// rec <= 255*D, so num < 2^33 and bits [32:9] hold the whole quotient input
	assign num = 35'({10'b0, rec_s3} * {26'b0, w_s3})
	           + 35'({18'b0, sw_s3} * {17'b0, DEN});

	assign prod = {17'b0, n_s4} * {24'b0, RECIP};

	// reciprocal estimate is low by at most one
	assign back = 25'({16'b0, q0_s5} * {9'b0, DIVISOR});
	assign rem  = {1'b0, n_s5} - back;
	assign q    = q0_s5 + {8'b0, (rem >= {9'b0, DIVISOR})};

	always_ff @(posedge clk) begin
		rec_s3   <= 25'({7'b0, terms.pn} * 25'd255) + 25'({7'b0, terms.d} * {17'b0, k});
		sw_s3    <= 17'({9'b0, src} * (17'(WEIGHT_FULL) - {8'b0, terms.w}));
		w_s3     <= terms.w;
		n_s4     <= num[32:9];
		q0_s5    <= prod[40:32];
		n_s5     <= n_s4;
		value_s6 <= (q > 9'd255) ? 8'd255 : q[7:0];
	end

	assign value = value_s6;

endmodule
`default_nettype wire
